// ----- design/hcb_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code builder package
// Shared payload types, function codes and controller states.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int SYM_W    = 8;
    localparam int WEIGHT_W = 24;
    localparam int LEN_W    = 6;
    localparam int BITS_W   = 64;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_FETCH = 1'b1;

    localparam logic [LEN_W-1:0] LEN_MAX = 6'd63;

    typedef struct packed {
        logic                func;
        logic [SYM_W-1:0]    symbol;
        logic [WEIGHT_W-1:0] weight;
        logic                load_last;
    } cmd_t;

    typedef struct packed {
        logic              valid_res;
        logic [SYM_W-1:0]  code_symbol;
        logic [LEN_W-1:0]  code_length;
        logic [BITS_W-1:0] code_bits;
        logic              final_code;
    } code_t;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [BITS_W-1:0] bits;
    } leaf_ent_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_FETCH,
        S_HFY_RD,
        S_HFY_LD,
        S_SIFT_RD,
        S_SIFT_CMP,
        S_MRG,
        S_EXT_RD,
        S_EXT_LD,
        S_INS,
        S_INS_CHK,
        S_INS_CMP,
        S_ROOT_RD,
        S_ROOT_LD,
        S_W_RD,
        S_W_EV,
        S_W_POP
    } state_t;

    typedef enum logic [1:0] {
        CTX_HFY,
        CTX_EXA,
        CTX_EXB
    } sift_ctx_t;

endpackage
`default_nettype wire

// ----- design/hcb_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code builder stream interface
// Valid/ready channel; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hcb_stream_if #(parameter type data_t = logic);

    logic  valid;
    logic  ready;
    data_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface
`default_nettype wire

// ----- design/hcb_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code builder single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- design/hcb_heap_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code builder heap RAM
// One write port and two read ports, so both children of a slot come together.
// ----------------------------------------------------------------------------
module hcb_heap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata0,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule
`default_nettype wire

// ----- design/huffman_code_builder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Huffman code builder
// Builds Huffman codes from loaded symbol weights with a RAM min-heap.
// ----------------------------------------------------------------------------
// The load marked last starts the build, during which no transfer is taken on
// cmd: the heap RAM is heapified and n-1 merges run, each of two extracts and
// one insert, where every heap level is a read, then a compare and write
// through the single write port of the heap RAM. The tree walk then reads
// and evaluates each node, pushing a right child on the stack at each inner
// node and popping one after each leaf but the last. A fetch reads its code
// from the leaf RAM and waits until the output register is free.
// ----------------------------------------------------------------------------
module huffman_code_builder #(
    parameter int MAX_SYMBOLS = 256
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    hcb_stream_if.sink   cmd,
    hcb_stream_if.source code
);

    localparam int IW = $clog2(MAX_SYMBOLS);
    localparam int CW = $clog2(MAX_SYMBOLS + 1);
    localparam int NODES = 2 * MAX_SYMBOLS - 1;
    localparam int NW = $clog2(NODES);
    localparam int DW = IW;
    localparam int WW = hcb_pkg::WEIGHT_W + IW;
    localparam int XW = IW + 2;

    typedef struct packed {
        logic [WW-1:0] w;
        logic [NW-1:0] node;
    } heap_ent_t;

    typedef struct packed {
        logic                     is_leaf;
        logic [hcb_pkg::SYM_W-1:0] sym;
        logic [NW-1:0]            left;
        logic [NW-1:0]            right;
    } node_ent_t;

    typedef struct packed {
        logic [NW-1:0]              node;
        logic [DW-1:0]              depth;
        logic [hcb_pkg::BITS_W-1:0] bits;
    } stack_ent_t;

    hcb_pkg::state_t    state_reg, state_next;
    hcb_pkg::sift_ctx_t ctx_reg, ctx_next;

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] size_reg, size_next;
    logic          set_closed_reg, set_closed_next;
    logic          tree_ready_reg, tree_ready_next;
    logic [IW-1:0] hfy_reg, hfy_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] ins_reg, ins_next;
    heap_ent_t     cur_reg, cur_next;
    heap_ent_t     a_reg, a_next;
    heap_ent_t     b_reg, b_next;
    logic [NW-1:0] nxt_reg, nxt_next;
    logic [NW-1:0] wnode_reg, wnode_next;
    logic [DW-1:0] depth_reg, depth_next;
    logic [hcb_pkg::BITS_W-1:0] bits_reg, bits_next;
    logic [IW-1:0] sp_reg, sp_next;
    logic [CW-1:0] leaf_total_reg, leaf_total_next;
    logic [CW-1:0] fetch_pos_reg, fetch_pos_next;
    logic          hit_reg, hit_next;
    logic          out_valid_reg, out_valid_next;
    hcb_pkg::code_t out_data_reg, out_data_next;

    logic            heap_we;
    logic [IW-1:0]   heap_waddr, heap_raddr0, heap_raddr1;
    heap_ent_t       heap_wdata;
    logic [$bits(heap_ent_t)-1:0] heap_rdata0, heap_rdata1;
    heap_ent_t       hrd0, hrd1;

    logic            node_we;
    logic [NW-1:0]   node_waddr;
    node_ent_t       node_wdata;
    logic [$bits(node_ent_t)-1:0] node_rdata;
    node_ent_t       nrd;

    logic            stk_we;
    stack_ent_t      stk_wdata;
    logic [IW-1:0]   stk_raddr;
    logic [$bits(stack_ent_t)-1:0] stk_rdata;
    stack_ent_t      srd;

    logic            leaf_we;
    logic [IW-1:0]   leaf_waddr;
    hcb_pkg::leaf_ent_t leaf_wdata;
    logic [$bits(hcb_pkg::leaf_ent_t)-1:0] leaf_rdata;
    hcb_pkg::leaf_ent_t lrd;

    logic [CW-1:0]   eff_count;
    logic            can_store;
    logic [XW-1:0]   lch, rch;
    logic            l_ok, r_ok, take_l, take_r;
    logic [WW-1:0]   small_w;
    logic            sift_stop;
    logic [IW-1:0]   parent;
    logic            out_free;

    assign hrd0 = heap_rdata0;
    assign hrd1 = heap_rdata1;
    assign nrd  = node_rdata;
    assign srd  = stk_rdata;
    assign lrd  = leaf_rdata;

    assign eff_count = set_closed_reg ? '0 : count_reg;
    assign can_store = eff_count < CW'(MAX_SYMBOLS);

    assign lch     = (XW'(idx_reg) << 1) + XW'(1);
    assign rch     = (XW'(idx_reg) << 1) + XW'(2);
    assign l_ok    = lch < XW'(size_reg);
    assign r_ok    = rch < XW'(size_reg);
    assign take_l  = l_ok && (hrd0.w < cur_reg.w);
    assign small_w = take_l ? hrd0.w : cur_reg.w;
    assign take_r  = r_ok && (hrd1.w < small_w);
    assign sift_stop = !take_l && !take_r;

    assign parent   = (ins_reg - IW'(1)) >> 1;
    assign out_free = !out_valid_reg || code.ready;

    assign stk_raddr = sp_reg - IW'(1);

    hcb_heap_ram #(
        .WIDTH ($bits(heap_ent_t)),
        .DEPTH (MAX_SYMBOLS)
    ) u_heap (
        .clk    (clk),
        .we     (heap_we),
        .waddr  (heap_waddr),
        .wdata  (heap_wdata),
        .raddr0 (heap_raddr0),
        .raddr1 (heap_raddr1),
        .rdata0 (heap_rdata0),
        .rdata1 (heap_rdata1)
    );

    hcb_ram #(
        .WIDTH ($bits(node_ent_t)),
        .DEPTH (NODES)
    ) u_nodes (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (wnode_reg),
        .rdata (node_rdata)
    );

    hcb_ram #(
        .WIDTH ($bits(stack_ent_t)),
        .DEPTH (MAX_SYMBOLS)
    ) u_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (sp_reg),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    hcb_ram #(
        .WIDTH ($bits(hcb_pkg::leaf_ent_t)),
        .DEPTH (MAX_SYMBOLS)
    ) u_leaves (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (leaf_waddr),
        .wdata (leaf_wdata),
        .raddr (fetch_pos_reg[IW-1:0]),
        .rdata (leaf_rdata)
    );

    assign cmd.ready  = (state_reg == hcb_pkg::S_IDLE);
    assign code.valid = out_valid_reg;
    assign code.data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcb_pkg::S_IDLE:
            begin
                if (cmd.valid)
                begin
                    if (cmd.data.func == hcb_pkg::FUNC_FETCH)
                    begin
                        state_next = hcb_pkg::S_FETCH;
                    end
                    else if (cmd.data.load_last)
                    begin
                        state_next = hcb_pkg::S_HFY_RD;
                    end
                end
            end
            hcb_pkg::S_FETCH:
            begin
                if (out_free)
                begin
                    state_next = hcb_pkg::S_IDLE;
                end
            end
            hcb_pkg::S_HFY_RD:  state_next = hcb_pkg::S_HFY_LD;
            hcb_pkg::S_HFY_LD:  state_next = hcb_pkg::S_SIFT_RD;
            hcb_pkg::S_SIFT_RD: state_next = hcb_pkg::S_SIFT_CMP;
            hcb_pkg::S_SIFT_CMP:
            begin
                if (!sift_stop)
                begin
                    state_next = hcb_pkg::S_SIFT_RD;
                end
                else
                begin
                    unique case (ctx_reg)
                        hcb_pkg::CTX_HFY:
                            state_next = (hfy_reg == '0) ? hcb_pkg::S_MRG : hcb_pkg::S_HFY_RD;
                        hcb_pkg::CTX_EXA: state_next = hcb_pkg::S_EXT_RD;
                        hcb_pkg::CTX_EXB: state_next = hcb_pkg::S_INS;
                        default:          state_next = hcb_pkg::S_IDLE;
                    endcase
                end
            end
            hcb_pkg::S_MRG:
                state_next = (size_reg > CW'(1)) ? hcb_pkg::S_EXT_RD : hcb_pkg::S_ROOT_RD;
            hcb_pkg::S_EXT_RD:  state_next = hcb_pkg::S_EXT_LD;
            hcb_pkg::S_EXT_LD:  state_next = hcb_pkg::S_SIFT_RD;
            hcb_pkg::S_INS:     state_next = hcb_pkg::S_INS_CHK;
            hcb_pkg::S_INS_CHK:
                state_next = (ins_reg == '0) ? hcb_pkg::S_MRG : hcb_pkg::S_INS_CMP;
            hcb_pkg::S_INS_CMP:
                state_next = (cur_reg.w < hrd0.w) ? hcb_pkg::S_INS_CHK : hcb_pkg::S_MRG;
            hcb_pkg::S_ROOT_RD: state_next = hcb_pkg::S_ROOT_LD;
            hcb_pkg::S_ROOT_LD: state_next = hcb_pkg::S_W_RD;
            hcb_pkg::S_W_RD:    state_next = hcb_pkg::S_W_EV;
            hcb_pkg::S_W_EV:
            begin
                if (!nrd.is_leaf)
                begin
                    state_next = hcb_pkg::S_W_RD;
                end
                else if (sp_reg == '0)
                begin
                    state_next = hcb_pkg::S_IDLE;
                end
                else
                begin
                    state_next = hcb_pkg::S_W_POP;
                end
            end
            hcb_pkg::S_W_POP:   state_next = hcb_pkg::S_W_RD;
            default:            state_next = hcb_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        ctx_next        = ctx_reg;
        count_next      = count_reg;
        size_next       = size_reg;
        set_closed_next = set_closed_reg;
        tree_ready_next = tree_ready_reg;
        hfy_next        = hfy_reg;
        idx_next        = idx_reg;
        ins_next        = ins_reg;
        cur_next        = cur_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        nxt_next        = nxt_reg;
        wnode_next      = wnode_reg;
        depth_next      = depth_reg;
        bits_next       = bits_reg;
        sp_next         = sp_reg;
        leaf_total_next = leaf_total_reg;
        fetch_pos_next  = fetch_pos_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg && !code.ready;
        out_data_next   = out_data_reg;

        heap_we     = 1'b0;
        heap_waddr  = idx_reg;
        heap_wdata  = cur_reg;
        heap_raddr0 = hfy_reg;
        heap_raddr1 = lch[IW-1:0];
        node_we     = 1'b0;
        node_waddr  = nxt_reg;
        node_wdata  = '0;
        stk_we      = 1'b0;
        stk_wdata   = '0;
        leaf_we     = 1'b0;
        leaf_waddr  = leaf_total_reg[IW-1:0];
        leaf_wdata  = '0;

        unique case (state_reg)
            hcb_pkg::S_IDLE:
            begin
                if (cmd.valid && cmd.data.func == hcb_pkg::FUNC_LOAD)
                begin
                    if (set_closed_reg)
                    begin
                        set_closed_next = 1'b0;
                        tree_ready_next = 1'b0;
                        leaf_total_next = '0;
                        fetch_pos_next  = '0;
                    end
                    count_next = eff_count;
                    if (can_store)
                    begin
                        node_we         = 1'b1;
                        node_waddr      = NW'(eff_count);
                        node_wdata.is_leaf = 1'b1;
                        node_wdata.sym  = cmd.data.symbol;
                        heap_we         = 1'b1;
                        heap_waddr      = eff_count[IW-1:0];
                        heap_wdata.w    = WW'(cmd.data.weight);
                        heap_wdata.node = NW'(eff_count);
                        count_next      = eff_count + CW'(1);
                    end
                    if (cmd.data.load_last)
                    begin
                        set_closed_next = 1'b1;
                        size_next       = count_next;
                        hfy_next        = IW'(count_next >> 1);
                        nxt_next        = NW'(count_next);
                        ctx_next        = hcb_pkg::CTX_HFY;
                    end
                end
                else if (cmd.valid)
                begin
                    hit_next = tree_ready_reg && (fetch_pos_reg < leaf_total_reg);
                end
            end
            hcb_pkg::S_FETCH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    if (hit_reg)
                    begin
                        out_data_next.valid_res   = 1'b1;
                        out_data_next.code_symbol = lrd.sym;
                        out_data_next.code_length = lrd.len;
                        out_data_next.code_bits   = lrd.bits;
                        out_data_next.final_code  =
                            (fetch_pos_reg + CW'(1)) == leaf_total_reg;
                        fetch_pos_next = fetch_pos_reg + CW'(1);
                    end
                end
            end
            hcb_pkg::S_HFY_RD:
            begin
                heap_raddr0 = hfy_reg;
            end
            hcb_pkg::S_HFY_LD:
            begin
                cur_next = hrd0;
                idx_next = hfy_reg;
            end
            hcb_pkg::S_SIFT_RD:
            begin
                heap_raddr0 = lch[IW-1:0];
                heap_raddr1 = rch[IW-1:0];
            end
            hcb_pkg::S_SIFT_CMP:
            begin
                heap_we    = 1'b1;
                heap_waddr = idx_reg;
                if (take_r)
                begin
                    heap_wdata = hrd1;
                    idx_next   = rch[IW-1:0];
                end
                else if (take_l)
                begin
                    heap_wdata = hrd0;
                    idx_next   = lch[IW-1:0];
                end
                else
                begin
                    heap_wdata = cur_reg;
                    if (ctx_reg == hcb_pkg::CTX_HFY)
                    begin
                        hfy_next = hfy_reg - IW'(1);
                    end
                    else if (ctx_reg == hcb_pkg::CTX_EXA)
                    begin
                        ctx_next = hcb_pkg::CTX_EXB;
                    end
                end
            end
            hcb_pkg::S_MRG:
            begin
                ctx_next = hcb_pkg::CTX_EXA;
            end
            hcb_pkg::S_EXT_RD:
            begin
                heap_raddr0 = '0;
                heap_raddr1 = IW'(size_reg - CW'(1));
            end
            hcb_pkg::S_EXT_LD:
            begin
                if (ctx_reg == hcb_pkg::CTX_EXA)
                begin
                    a_next = hrd0;
                end
                else
                begin
                    b_next = hrd0;
                end
                cur_next  = hrd1;
                size_next = size_reg - CW'(1);
                idx_next  = '0;
            end
            hcb_pkg::S_INS:
            begin
                node_we          = 1'b1;
                node_waddr       = nxt_reg;
                node_wdata.left  = a_reg.node;
                node_wdata.right = b_reg.node;
                cur_next.w       = a_reg.w + b_reg.w;
                cur_next.node    = nxt_reg;
                ins_next         = size_reg[IW-1:0];
                size_next        = size_reg + CW'(1);
                nxt_next         = nxt_reg + NW'(1);
            end
            hcb_pkg::S_INS_CHK:
            begin
                heap_raddr0 = parent;
                if (ins_reg == '0)
                begin
                    heap_we    = 1'b1;
                    heap_waddr = '0;
                    heap_wdata = cur_reg;
                end
            end
            hcb_pkg::S_INS_CMP:
            begin
                heap_we    = 1'b1;
                heap_waddr = ins_reg;
                if (cur_reg.w < hrd0.w)
                begin
                    heap_wdata = hrd0;
                    ins_next   = parent;
                end
                else
                begin
                    heap_wdata = cur_reg;
                end
            end
            hcb_pkg::S_ROOT_RD:
            begin
                heap_raddr0 = '0;
            end
            hcb_pkg::S_ROOT_LD:
            begin
                wnode_next      = hrd0.node;
                depth_next      = '0;
                bits_next       = '0;
                sp_next         = '0;
                leaf_total_next = '0;
            end
            hcb_pkg::S_W_RD:
            begin
                wnode_next = wnode_reg;
            end
            hcb_pkg::S_W_EV:
            begin
                if (nrd.is_leaf)
                begin
                    leaf_we         = 1'b1;
                    leaf_wdata.sym  = nrd.sym;
                    leaf_wdata.len  = (32'(depth_reg) > 32'(hcb_pkg::LEN_MAX)) ?
                                      hcb_pkg::LEN_MAX : hcb_pkg::LEN_W'(depth_reg);
                    leaf_wdata.bits = bits_reg;
                    leaf_total_next = leaf_total_reg + CW'(1);
                    if (sp_reg == '0)
                    begin
                        tree_ready_next = 1'b1;
                        fetch_pos_next  = '0;
                    end
                    else
                    begin
                        sp_next = sp_reg - IW'(1);
                    end
                end
                else
                begin
                    stk_we          = 1'b1;
                    stk_wdata.node  = nrd.right;
                    stk_wdata.depth = depth_reg + DW'(1);
                    stk_wdata.bits  = {bits_reg[hcb_pkg::BITS_W-2:0], 1'b1};
                    sp_next         = sp_reg + IW'(1);
                    wnode_next      = nrd.left;
                    depth_next      = depth_reg + DW'(1);
                    bits_next       = {bits_reg[hcb_pkg::BITS_W-2:0], 1'b0};
                end
            end
            hcb_pkg::S_W_POP:
            begin
                wnode_next = srd.node;
                depth_next = srd.depth;
                bits_next  = srd.bits;
            end
            default:
            begin
                ctx_next = ctx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hcb_pkg::S_IDLE;
            ctx_reg        <= hcb_pkg::CTX_HFY;
            count_reg      <= '0;
            size_reg       <= '0;
            set_closed_reg <= 1'b0;
            tree_ready_reg <= 1'b0;
            hfy_reg        <= '0;
            idx_reg        <= '0;
            ins_reg        <= '0;
            nxt_reg        <= '0;
            sp_reg         <= '0;
            leaf_total_reg <= '0;
            fetch_pos_reg  <= '0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ctx_reg        <= ctx_next;
            count_reg      <= count_next;
            size_reg       <= size_next;
            set_closed_reg <= set_closed_next;
            tree_ready_reg <= tree_ready_next;
            hfy_reg        <= hfy_next;
            idx_reg        <= idx_next;
            ins_reg        <= ins_next;
            nxt_reg        <= nxt_next;
            sp_reg         <= sp_next;
            leaf_total_reg <= leaf_total_next;
            fetch_pos_reg  <= fetch_pos_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        wnode_reg    <= wnode_next;
        depth_reg    <= depth_next;
        bits_reg     <= bits_next;
        out_data_reg <= out_data_next;
    end

`ifndef ASSERT_OFF
    a_fetch_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fetch_pos_reg <= leaf_total_reg)
        else $error("fetch position ran past the number of codes");

    a_leaf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        leaf_total_reg <= count_reg)
        else $error("more codes than loaded symbols");

    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        size_reg <= count_reg)
        else $error("heap size exceeds symbol count");

    a_ready_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tree_ready_reg) |-> $past(state_reg) == hcb_pkg::S_W_EV)
        else $error("tree marked ready outside the tree walk");
`endif

endmodule
`default_nettype wire
